[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication, masked while reset is applied.
`define FCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked while reset is applied.
`define FCL_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[sv/fcl_pkg.sv]
// ---------------------------------------------------------------------------
// fcl_pkg
// Request codes, sequencer states and field widths of the fully connected layer unit.
// ---------------------------------------------------------------------------
package fcl_pkg;

  typedef enum logic [2:0] {
    REQ_LOAD_W = 3'd0,
    REQ_LOAD_B = 3'd1,
    REQ_LOAD_X = 3'd2,
    REQ_FWD    = 3'd3,
    REQ_DY     = 3'd4,
    REQ_DX     = 3'd5,
    REQ_READ   = 3'd6,
    REQ_CLEAR  = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_READ
  } state_t;

  localparam int unsigned FIELD_BITS = 16;
  localparam int unsigned INDEX_BITS = 6;

endpackage

[sv/fully_connected_layer_fwd_bwd_unit.sv]
// Forward run: one multiply-accumulate per cycle through the weight memory
// port; results stream out one per row.
// Dy item: read, multiply and write back, one column a cycle.
// After reset and on a clear request the gradient memory is swept to zero
// while busy is high. Results cannot be stalled.
// ---------------------------------------------------------------------------
// fully_connected_layer_fwd_bwd_unit
// Fully connected layer engine, forward and backward, in Q8.8 fixed point.
// ---------------------------------------------------------------------------
module fully_connected_layer_fwd_bwd_unit
  import fcl_pkg::*;
#(
  parameter int IN_LEN    = 64,
  parameter int OUT_LEN   = 16,
  parameter int DATA_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [3:0]  in_row,
  input  logic [5:0]  in_col,
  input  logic        in_bias_select,
  input  logic signed [15:0] in_value,
  output logic        out_valid,
  output logic signed [15:0] out_result_value,
  output logic [5:0]  out_result_index,
  output logic        out_last
);

  localparam int WDEPTH = OUT_LEN * IN_LEN;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int XAW    = (IN_LEN > 1) ? $clog2(IN_LEN) : 1;
  localparam int RAW    = (OUT_LEN > 1) ? $clog2(OUT_LEN) : 1;
  localparam int DB     = DATA_BITS;
  localparam int ACC_W  = 2 * DB + XAW + 1;
  localparam int SAT_W  = ACC_W + 2;

  localparam logic signed [SAT_W-1:0] DMAX = SAT_W'((64'sd1 <<< (DB - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] DMIN = -DMAX - SAT_W'(1);
  localparam logic signed [SAT_W-1:0] FMAX = SAT_W'(32767);
  localparam logic signed [SAT_W-1:0] FMIN = -FMAX - SAT_W'(1);
  localparam logic signed [SAT_W-1:0] HALF = SAT_W'(128);

  function automatic logic signed [DB-1:0] sat_db(input logic signed [SAT_W-1:0] v);
    if (v > DMAX) begin
      return DMAX[DB-1:0];
    end else if (v < DMIN) begin
      return DMIN[DB-1:0];
    end
    return v[DB-1:0];
  endfunction

  function automatic logic signed [15:0] sat_out(input logic signed [SAT_W-1:0] v);
    if (v > FMAX) begin
      return FMAX[15:0];
    end else if (v < FMIN) begin
      return FMIN[15:0];
    end
    return v[15:0];
  endfunction

  // Round a Q16.16 value to Q8.8, ties toward plus infinity.
  function automatic logic signed [SAT_W-1:0] rnd(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] t;
    t = v + HALF;
    return t >>> 8;
  endfunction

  state_t state_r, state_nxt;
  req_t   mode_r;
  req_t   req;
  logic   accept;
  logic   row_ok, col_ok;
  logic signed [DB-1:0] val_db;
  logic [WAW-1:0] in_addr;

  logic [WAW-1:0] a_r;
  logic [XAW-1:0] k_r;
  logic [RAW-1:0] j_r;
  logic           k_end, j_end, a_end, iss_last, done;
  logic signed [DB-1:0] dy_r;

  // Stage tags.
  logic           s1_v_r, s1_first_r, s1_last_r;
  logic [RAW-1:0] s1_j_r;
  logic [XAW-1:0] s1_k_r;
  logic [WAW-1:0] s1_a_r;
  logic           s2_v_r, s2_first_r, s2_last_r;
  logic [RAW-1:0] s2_j_r;
  logic [XAW-1:0] s2_k_r;
  logic [WAW-1:0] s2_a_r;

  logic signed [2*DB-1:0] prod_a_r, prod_b_r;
  logic signed [DB-1:0]   wg_d_r, ig_d_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, fin_acc_r;
  logic           fin_v_r;
  logic [RAW-1:0] fin_j_r;

  logic           rd_bsel_r, rd_ok_r;
  logic [5:0]     rd_idx_r;
  logic [RAW-1:0] rd_row_r;

  logic signed [DB-1:0] bias_r [OUT_LEN];
  logic signed [DB-1:0] bg_r   [OUT_LEN];

  // Memory ports.
  logic           w_we, x_we, wg_we, ig_we;
  logic [WAW-1:0] wg_waddr, wg_raddr;
  logic [XAW-1:0] ig_waddr;
  logic [DB-1:0]  wg_wdata, ig_wdata;
  logic [DB-1:0]  w_q, x_q, wg_q, ig_q;
  logic signed [DB-1:0] wg_upd, ig_upd;

  logic           out_valid_r, out_last_r;
  logic signed [15:0] out_value_r;
  logic [5:0]     out_index_r;

  assign req     = req_t'(in_req_type);
  assign accept  = start && !busy;
  assign row_ok  = {3'b000, in_row} < 7'(OUT_LEN);
  assign col_ok  = {1'b0, in_col} < 7'(IN_LEN);
  assign val_db  = sat_db(SAT_W'(in_value));
  assign in_addr = WAW'(in_row) * WAW'(IN_LEN) + WAW'(in_col);

  assign k_end    = (k_r == XAW'(IN_LEN - 1));
  assign j_end    = (j_r == RAW'(OUT_LEN - 1));
  assign a_end    = (a_r == WAW'(WDEPTH - 1));
  assign iss_last = (mode_r == REQ_FWD) ? (k_end && j_end) : k_end;

  always_comb begin
    unique case (mode_r)
      REQ_FWD: done = fin_v_r && (fin_j_r == RAW'(OUT_LEN - 1));
      REQ_DY:  done = s2_v_r && s2_last_r;
      default: done = s1_v_r && s1_last_r;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (a_end) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (req)
            REQ_FWD, REQ_DX: state_nxt = S_ISSUE;
            REQ_DY:          state_nxt = row_ok ? S_ISSUE : S_IDLE;
            REQ_READ:        state_nxt = S_READ;
            REQ_CLEAR:       state_nxt = S_CLEAR;
            default:         state_nxt = S_IDLE;
          endcase
        end
      end
      S_ISSUE: if (iss_last) state_nxt = S_DRAIN;
      S_DRAIN: if (done) state_nxt = S_IDLE;
      S_READ:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign wg_upd = sat_db(SAT_W'(wg_d_r) + rnd(SAT_W'(prod_b_r)));
  assign ig_upd = sat_db(SAT_W'(ig_d_r) + rnd(SAT_W'(prod_a_r)));

  // Outputs of the sequencer: handshake and memory controls.
  always_comb begin
    busy     = (state_r != S_IDLE);
    w_we     = (state_r == S_IDLE) && accept && (req == REQ_LOAD_W) && row_ok && col_ok;
    x_we     = (state_r == S_IDLE) && accept && (req == REQ_LOAD_X) && col_ok;
    wg_we    = 1'b0;
    wg_waddr = a_r;
    wg_wdata = '0;
    ig_we    = 1'b0;
    ig_waddr = k_r;
    ig_wdata = '0;
    wg_raddr = (state_r == S_IDLE) ? in_addr : a_r;
    if (state_r == S_CLEAR) begin
      wg_we    = 1'b1;
      ig_we    = {1'b0, a_r} < (WAW + 1)'(IN_LEN);
      ig_waddr = XAW'(a_r);
    end else if (s2_v_r && (mode_r == REQ_DY)) begin
      wg_we    = 1'b1;
      wg_waddr = s2_a_r;
      wg_wdata = wg_upd;
      ig_we    = 1'b1;
      ig_waddr = s2_k_r;
      ig_wdata = ig_upd;
    end else if ((state_r == S_ISSUE) && (mode_r == REQ_DX)) begin
      ig_we = 1'b1;
    end
  end

  fcl_ram #(.DEPTH(WDEPTH), .WIDTH(DB), .AW(WAW)) u_w_ram (
    .clk(clk), .we(w_we), .waddr(in_addr), .wdata(val_db),
    .raddr(a_r), .rdata(w_q)
  );

  fcl_ram #(.DEPTH(IN_LEN), .WIDTH(DB), .AW(XAW)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(XAW'(in_col)), .wdata(val_db),
    .raddr(k_r), .rdata(x_q)
  );

  fcl_ram #(.DEPTH(WDEPTH), .WIDTH(DB), .AW(WAW)) u_wg_ram (
    .clk(clk), .we(wg_we), .waddr(wg_waddr), .wdata(wg_wdata),
    .raddr(wg_raddr), .rdata(wg_q)
  );

  fcl_ram #(.DEPTH(IN_LEN), .WIDTH(DB), .AW(XAW)) u_ig_ram (
    .clk(clk), .we(ig_we), .waddr(ig_waddr), .wdata(ig_wdata),
    .raddr(k_r), .rdata(ig_q)
  );

  // Control registers and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      mode_r  <= REQ_CLEAR;
      a_r     <= '0;
      k_r     <= '0;
      j_r     <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      fin_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= (state_r == S_ISSUE);
      s2_v_r  <= s1_v_r;
      fin_v_r <= s2_v_r && s2_last_r && (mode_r == REQ_FWD);
      unique case (state_r)
        S_CLEAR: a_r <= a_r + WAW'(1);
        S_IDLE: begin
          if (accept) begin
            mode_r <= req;
            k_r    <= '0;
            j_r    <= '0;
            a_r    <= (req == REQ_DY) ? WAW'(in_row) * WAW'(IN_LEN) : '0;
          end
        end
        S_ISSUE: begin
          a_r <= a_r + WAW'(1);
          if (k_end) begin
            k_r <= '0;
            j_r <= j_r + RAW'(1);
          end else begin
            k_r <= k_r + XAW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Bias and bias-gradient registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < OUT_LEN; i++) bg_r[i] <= '0;
    end else if (accept) begin
      if (req == REQ_CLEAR) begin
        for (int i = 0; i < OUT_LEN; i++) bg_r[i] <= '0;
      end else if ((req == REQ_DY) && row_ok) begin
        bg_r[RAW'(in_row)] <= sat_db(SAT_W'(bg_r[RAW'(in_row)]) + SAT_W'(val_db));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req == REQ_LOAD_B) && row_ok) begin
      bias_r[RAW'(in_row)] <= val_db;
    end
    if (accept) begin
      dy_r      <= val_db;
      rd_bsel_r <= in_bias_select;
      rd_ok_r   <= in_bias_select ? row_ok : (row_ok && col_ok);
      rd_idx_r  <= in_bias_select ? {2'b00, in_row} : in_col;
      rd_row_r  <= RAW'(in_row);
    end
  end

  // Datapath stages.
  assign acc_nxt = (s2_first_r ? '0 : acc_r) + ACC_W'(prod_a_r);

  always_ff @(posedge clk) begin
    s1_first_r <= (k_r == '0);
    s1_last_r  <= iss_last;
    s1_j_r     <= j_r;
    s1_k_r     <= k_r;
    s1_a_r     <= a_r;
    s2_first_r <= s1_first_r;
    s2_last_r  <= (mode_r == REQ_FWD) ? (s1_k_r == XAW'(IN_LEN - 1)) : s1_last_r;
    s2_j_r     <= s1_j_r;
    s2_k_r     <= s1_k_r;
    s2_a_r     <= s1_a_r;
    prod_a_r   <= $signed(w_q) * ((mode_r == REQ_FWD) ? $signed(x_q) : dy_r);
    prod_b_r   <= dy_r * $signed(x_q);
    wg_d_r     <= wg_q;
    ig_d_r     <= ig_q;
    if (s2_v_r) begin
      acc_r <= acc_nxt;
    end
    fin_acc_r <= acc_nxt;
    fin_j_r   <= s2_j_r;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin_v_r || (s1_v_r && (mode_r == REQ_DX)) || (state_r == S_READ);
    end
    if (fin_v_r) begin
      out_value_r <= sat_out(SAT_W'(sat_db(rnd(SAT_W'(fin_acc_r)) +
                                           SAT_W'(bias_r[fin_j_r]))));
      out_index_r <= 6'(fin_j_r);
      out_last_r  <= (fin_j_r == RAW'(OUT_LEN - 1));
    end else if (state_r == S_READ) begin
      if (!rd_ok_r) begin
        out_value_r <= '0;
      end else if (rd_bsel_r) begin
        out_value_r <= sat_out(SAT_W'(bg_r[rd_row_r]));
      end else begin
        out_value_r <= sat_out(SAT_W'($signed(wg_q)));
      end
      out_index_r <= rd_idx_r;
      out_last_r  <= 1'b1;
    end else begin
      out_value_r <= sat_out(SAT_W'($signed(ig_q)));
      out_index_r <= 6'(s1_k_r);
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_result_index = out_index_r;
  assign out_last         = out_last_r;

endmodule

[sv/fcl_ram.sv]
// ---------------------------------------------------------------------------
// fcl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module fcl_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/fcl_checker.sv]
// ---------------------------------------------------------------------------
// fcl_checker
// Port-level checks of the fully connected layer unit, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fcl_checker
  import fcl_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [2:0]  in_req_type,
  input logic        out_valid,
  input logic        out_last
);

  logic silent_beat;
  logic read_beat;

  // Requests that never produce a result beat.
  assign silent_beat = start && !busy &&
    ((in_req_type == REQ_LOAD_W) || (in_req_type == REQ_LOAD_B) ||
     (in_req_type == REQ_LOAD_X) || (in_req_type == REQ_DY) ||
     (in_req_type == REQ_CLEAR));
  assign read_beat = start && !busy && (in_req_type == REQ_READ);

  `FCL_ASSERT_NEXT_ALWAYS(a_reset_busy, !rst_n, busy, "unit not busy after reset")
  `FCL_ASSERT_NEXT_ALWAYS(a_reset_quiet, !rst_n, !out_valid, "result beat after reset")
  `FCL_ASSERT_NEXT(a_silent, silent_beat, !out_valid, "silent request gave a result beat")
  `FCL_ASSERT_NEXT(a_read, read_beat, ##1 (out_valid && out_last), "gradient read lost")

endmodule

bind fully_connected_layer_fwd_bwd_unit fcl_checker u_fcl_checker (.*);
